>>> src/ble_pkg.sv
// ----------------------------------------------------------------------------
// ble_pkg
// Constants, register indexes and sequencer states of the battery level
// estimator.
// ----------------------------------------------------------------------------
package ble_pkg;

  // burst shape: warm-up reads are dropped, averaged reads are summed
  localparam int WARMUP_READS   = 4;
  localparam int AVERAGED_READS = 12;
  localparam int BURST_LEN      = WARMUP_READS + AVERAGED_READS;
  localparam int POS_W          = 5;

  // adc scaling: pin_mv = raw * ADC_REF_MV / ADC_FULL_CODE
  localparam int ADC_REF_MV     = 3300;
  localparam int ADC_FULL_CODE  = 4095;
  localparam int PERCENT_FULL   = 100;
  localparam int Q8_HALF        = 128;

  // shared restoring divider: 24-bit dividend, 16-bit divisor
  localparam int DIV_STEPS      = 24;
  localparam int DIV_CNT_W      = 5;

  // configuration reset values
  localparam logic [15:0] EMPTY_MV_RESET = 16'd3300;
  localparam logic [15:0] FULL_MV_RESET  = 16'd4200;
  localparam logic [15:0] OPEN_MV_RESET  = 16'd2500;
  localparam logic [11:0] RATIO_RESET    = 12'd512;

  typedef enum logic [1:0] {
    REG_EMPTY_MV = 2'd0,
    REG_FULL_MV  = 2'd1,
    REG_OPEN_MV  = 2'd2,
    REG_RATIO_Q8 = 2'd3
  } cfg_reg_t;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_AVG_DIV = 10'b00_0000_0010,
    ST_MUL_PIN = 10'b00_0000_0100,
    ST_PIN_DIV = 10'b00_0000_1000,
    ST_MUL_BAT = 10'b00_0001_0000,
    ST_VBAT    = 10'b00_0010_0000,
    ST_CLASS   = 10'b00_0100_0000,
    ST_MUL_PCT = 10'b00_1000_0000,
    ST_PCT_DIV = 10'b01_0000_0000,
    ST_SMOOTH  = 10'b10_0000_0000
  } state_t;

endpackage

>>> src/battery_level_estimator_unit.sv
// ----------------------------------------------------------------------------
// battery_level_estimator_unit
// Averages a burst of ADC reads and turns the average into battery millivolts
// and a smoothed charge percent, one result per burst.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  tdata: sample_raw, tuser: sample_ok
// m_*       out        m_tvalid/m_tready  tdata: battery_mv, level_percent,
//                                         tuser: read_failed
// cfg_*     in         cfg_we             cfg_addr, cfg_wdata
//
// Every item but the last of a burst is taken while the sequencer is idle. The
// last item starts it if the burst held a good read: a pass of the shared
// 24-step restoring divider by the good count, another by the full-empty span
// if the percent needs division, up to seven more steps. rst is synchronous and
// active high. s_tready is low while the sequencer runs, and low for the last
// item of a burst while an earlier result still waits in the output register.

module battery_level_estimator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // [11:0] sample_raw
  input  logic        s_tuser,    // [0] sample_ok
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [16:0] battery_mv, [24:17] level_percent
  output logic        m_tuser,    // [0] read_failed
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  ble_pkg::state_t state;

  logic [15:0] empty_mv;
  logic [15:0] full_mv;
  logic [15:0] open_mv;
  logic [11:0] ratio_q8;

  logic [ble_pkg::POS_W-1:0] burst_pos;
  logic [15:0] raw_sum;
  logic [3:0]  good_reads;
  logic signed [7:0]  last_percent;
  logic signed [16:0] last_mv;
  logic        out_valid;
  logic        out_failed;

  // shared divider
  logic [23:0] quo;
  logic [15:0] rem;
  logic [15:0] den;
  logic [ble_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [16:0] div_trial;
  logic [16:0] div_diff;
  logic        div_ge;
  logic        div_done;

  // shared multiplier
  logic [15:0] mul_a;
  logic [11:0] mul_b;
  logic [27:0] mul_p;

  logic [23:0] prod;
  logic [24:0] pin_sum;
  logic [15:0] vbat;
  logic [24:0] vbat_round;
  logic [15:0] span_diff;
  logic signed [7:0] pct;
  logic [8:0]  smooth_sum;

  logic        accept;
  logic        last_read;
  logic [15:0] raw_sum_next;
  logic [3:0]  good_reads_next;
  logic        take_read;

  assign last_read = (burst_pos == ble_pkg::POS_W'(ble_pkg::BURST_LEN - 1));
  assign s_tready  = (state == ble_pkg::ST_IDLE) && !(out_valid && last_read);
  assign accept    = s_tvalid && s_tready;
  assign take_read = (burst_pos >= ble_pkg::POS_W'(ble_pkg::WARMUP_READS)) && s_tuser;

  always_comb begin
    raw_sum_next    = raw_sum;
    good_reads_next = good_reads;
    if (take_read) begin
      raw_sum_next    = raw_sum + {4'd0, s_tdata[11:0]};
      good_reads_next = good_reads + 4'd1;
    end
  end

  // one restoring step per cycle
  assign div_trial = {rem, quo[23]};
  assign div_diff  = div_trial - {1'b0, den};
  assign div_ge    = (div_trial >= {1'b0, den});
  assign div_done  = (div_cnt == ble_pkg::DIV_CNT_W'(ble_pkg::DIV_STEPS - 1));

  // x / 4095 as (x + (x >> 12) + 1) >> 12, exact while the quotient fits 12 bits
  assign pin_sum = {1'b0, quo} + {13'd0, quo[23:12]} + 25'd1;

  always_comb begin
    mul_a = {4'd0, quo[11:0]};
    mul_b = 12'(ble_pkg::ADC_REF_MV);
    unique case (state)
      ble_pkg::ST_MUL_BAT: begin
        mul_a = {4'd0, quo[11:0]};
        mul_b = ratio_q8;
      end
      ble_pkg::ST_MUL_PCT: begin
        mul_a = span_diff;
        mul_b = 12'(ble_pkg::PERCENT_FULL);
      end
      default: begin
        mul_a = {4'd0, quo[11:0]};
        mul_b = 12'(ble_pkg::ADC_REF_MV);
      end
    endcase
  end

  assign mul_p      = 28'(mul_a) * 28'(mul_b);
  assign vbat_round = {1'b0, prod} + 25'(ble_pkg::Q8_HALF);
  assign smooth_sum = 9'(last_percent[6:0]) * 9'd3 + 9'(pct[6:0]);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      empty_mv <= ble_pkg::EMPTY_MV_RESET;
      full_mv  <= ble_pkg::FULL_MV_RESET;
      open_mv  <= ble_pkg::OPEN_MV_RESET;
      ratio_q8 <= ble_pkg::RATIO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ble_pkg::REG_EMPTY_MV: empty_mv <= cfg_wdata;
        ble_pkg::REG_FULL_MV:  full_mv  <= cfg_wdata;
        ble_pkg::REG_OPEN_MV:  open_mv  <= cfg_wdata;
        ble_pkg::REG_RATIO_Q8: ratio_q8 <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ble_pkg::ST_IDLE;
      burst_pos    <= '0;
      raw_sum      <= '0;
      good_reads   <= '0;
      last_percent <= -8'sd1;
      last_mv      <= -17'sd1;
      out_valid    <= 1'b0;
      out_failed   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ble_pkg::ST_IDLE: begin
          if (accept) begin
            if (last_read) begin
              burst_pos  <= '0;
              raw_sum    <= '0;
              good_reads <= '0;
              if (good_reads_next == 4'd0) begin
                // nothing good in the burst: held values, failure flag
                out_failed <= 1'b1;
                out_valid  <= 1'b1;
              end else begin
                state <= ble_pkg::ST_AVG_DIV;
              end
            end else begin
              burst_pos  <= burst_pos + 1'b1;
              raw_sum    <= raw_sum_next;
              good_reads <= good_reads_next;
            end
          end
        end
        ble_pkg::ST_AVG_DIV: if (div_done) state <= ble_pkg::ST_MUL_PIN;
        ble_pkg::ST_MUL_PIN: state <= ble_pkg::ST_PIN_DIV;
        ble_pkg::ST_PIN_DIV: state <= ble_pkg::ST_MUL_BAT;
        ble_pkg::ST_MUL_BAT: state <= ble_pkg::ST_VBAT;
        ble_pkg::ST_VBAT:    state <= ble_pkg::ST_CLASS;
        ble_pkg::ST_CLASS: begin
          if ((vbat < open_mv) || (vbat <= empty_mv) || (vbat >= full_mv)) begin
            state <= ble_pkg::ST_SMOOTH;
          end else begin
            state <= ble_pkg::ST_MUL_PCT;
          end
        end
        ble_pkg::ST_MUL_PCT: state <= ble_pkg::ST_PCT_DIV;
        ble_pkg::ST_PCT_DIV: if (div_done) state <= ble_pkg::ST_SMOOTH;
        ble_pkg::ST_SMOOTH: begin
          if (!pct[7] && !last_percent[7]) begin
            last_percent <= {1'b0, smooth_sum[8:2]};
          end else begin
            last_percent <= pct;
          end
          last_mv    <= {1'b0, vbat};
          out_failed <= 1'b0;
          out_valid  <= 1'b1;
          state      <= ble_pkg::ST_IDLE;
        end
        default: state <= ble_pkg::ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ble_pkg::ST_IDLE: begin
        quo     <= {8'd0, raw_sum_next};
        rem     <= '0;
        den     <= {12'd0, good_reads_next};
        div_cnt <= '0;
      end
      ble_pkg::ST_AVG_DIV, ble_pkg::ST_PCT_DIV: begin
        rem     <= div_ge ? div_diff[15:0] : div_trial[15:0];
        quo     <= {quo[22:0], div_ge};
        div_cnt <= div_cnt + 1'b1;
      end
      ble_pkg::ST_MUL_PIN: begin
        quo <= mul_p[23:0];
      end
      ble_pkg::ST_PIN_DIV: begin
        quo <= {11'd0, pin_sum[24:12]};
      end
      ble_pkg::ST_MUL_BAT: begin
        prod <= mul_p[23:0];
      end
      ble_pkg::ST_VBAT: begin
        vbat <= (vbat_round[24]) ? 16'hFFFF : vbat_round[23:8];
      end
      ble_pkg::ST_CLASS: begin
        span_diff <= vbat - empty_mv;
        if (vbat < open_mv) begin
          pct <= -8'sd1;
        end else if (vbat <= empty_mv) begin
          pct <= 8'sd0;
        end else if (vbat >= full_mv) begin
          pct <= 8'(ble_pkg::PERCENT_FULL);
        end
      end
      ble_pkg::ST_MUL_PCT: begin
        quo     <= mul_p[23:0];
        rem     <= '0;
        den     <= full_mv - empty_mv;
        div_cnt <= '0;
      end
      ble_pkg::ST_SMOOTH: ;
      default: ;
    endcase
    // quotient of the span division is below one hundred
    if ((state == ble_pkg::ST_PCT_DIV) && div_done) begin
      pct <= {1'b0, quo[5:0], div_ge};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, last_percent, last_mv};
  assign m_tuser  = out_failed;

  // a result never waits while the sequencer overwrites the held values
  assert property (@(posedge clk) disable iff (rst)
    (state != ble_pkg::ST_IDLE) |-> !out_valid)
    else $error("sequencer running with a result pending");

  // divider remainder stays below the divisor
  assert property (@(posedge clk) disable iff (rst)
    ((state == ble_pkg::ST_AVG_DIV) || (state == ble_pkg::ST_PCT_DIV)) |-> (rem < den))
    else $error("divider remainder out of range");

  // reported percent is unknown or within zero to one hundred
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((last_percent >= -8'sd1) && (last_percent <= 8'sd100)))
    else $error("percent out of range");

  // burst counter wraps at the burst length
  assert property (@(posedge clk) disable iff (rst)
    (accept && last_read) |=> (burst_pos == '0))
    else $error("burst position did not restart");

endmodule
